### rtl/r2h_pkg.sv
// r2h_pkg: shared widths, constants and types of the RGB to HSV converter.
// No dependencies; imported by r2h_div and rgb_to_hsv_converter.
package r2h_pkg;

    localparam int CHANNEL_BITS      = 8;
    localparam int HUE_FRACTION_BITS = 3;

    localparam int HUE_BITS   = 9 + HUE_FRACTION_BITS;
    localparam int SECTOR     = 60 * (2 ** HUE_FRACTION_BITS);
    localparam int FULL_SCALE = (2 ** CHANNEL_BITS) - 1;

    // Quotient must hold both the sector offset (<= SECTOR) and the saturation.
    localparam int QUOT_BITS = (6 + HUE_FRACTION_BITS > CHANNEL_BITS) ?
                               (6 + HUE_FRACTION_BITS) : CHANNEL_BITS;
    localparam int DEN_BITS  = CHANNEL_BITS + 1;
    localparam int REM_BITS  = DEN_BITS + QUOT_BITS;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef struct packed {
        sector_t                 sector;
        logic                    neg;
        logic                    achromatic;
        logic [CHANNEL_BITS-1:0] brightness;
    } side_t;

    typedef struct packed {
        side_t                   side;
        logic [CHANNEL_BITS-1:0] mag;
        logic [CHANNEL_BITS-1:0] spread;
    } front_t;

endpackage

### rtl/rgb_to_hsv_converter.sv
// rgb_to_hsv_converter: pipelined RGB to HSV pixel converter (top level).
// Depends on r2h_pkg and r2h_div.
// Stages: max/min stage, numerator stage, one divider stage per quotient bit,
// output stage.
// Throughput: one pixel per cycle; each stage holds under backpressure, bubbles close up.
// Reset: asynchronous, active low, clears all valid bits; payload is not reset.
module rgb_to_hsv_converter
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [r2h_pkg::CHANNEL_BITS-1:0]   red,
    input  logic [r2h_pkg::CHANNEL_BITS-1:0]   green,
    input  logic [r2h_pkg::CHANNEL_BITS-1:0]   blue,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [r2h_pkg::HUE_BITS-1:0]       hue,
    output logic [r2h_pkg::CHANNEL_BITS-1:0]   saturation,
    output logic [r2h_pkg::CHANNEL_BITS-1:0]   brightness,
    output logic                               achromatic
);
    import r2h_pkg::*;

    localparam int CB = CHANNEL_BITS;

    // stage 0: max, min, sector, signed channel difference
    logic                s0_valid_reg;
    logic                s0_ready;
    front_t              s0_reg;
    front_t              s0_next;
    logic [CB-1:0]       mx;
    logic [CB-1:0]       mn;
    logic [CB-1:0]       op_a;
    logic [CB-1:0]       op_b;

    // stage 1: dividends and divisors
    logic                s1_valid_reg;
    logic                s1_ready;
    side_t               s1_side_reg;
    logic [REM_BITS-1:0] num_h_reg;
    logic [REM_BITS-1:0] num_s_reg;
    logic [DEN_BITS-1:0] den_h_reg;
    logic [DEN_BITS-1:0] den_s_reg;
    logic [REM_BITS-1:0] num_h_next;
    logic [REM_BITS-1:0] num_s_next;
    logic [DEN_BITS-1:0] den_h_next;
    logic [DEN_BITS-1:0] den_s_next;

    // divider
    logic                 div_in_ready;
    logic                 div_out_valid;
    logic [QUOT_BITS-1:0] div_quo_h;
    logic [QUOT_BITS-1:0] div_quo_s;
    side_t                div_side;

    // output stage
    logic                out_valid_reg;
    logic                out_stage_ready;
    logic [HUE_BITS-1:0] hue_reg;
    logic [CB-1:0]       sat_reg;
    logic [CB-1:0]       bright_reg;
    logic                achrom_reg;
    logic [HUE_BITS-1:0] hue_next;
    logic [CB-1:0]       sat_next;
    logic [HUE_BITS-1:0] qh;

    assign out_stage_ready = ~out_valid_reg | out_ready;
    assign s1_ready        = ~s1_valid_reg | div_in_ready;
    assign s0_ready        = ~s0_valid_reg | s1_ready;
    assign in_ready        = s0_ready;

    always_comb
    begin
        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
    end

    always_comb
    begin
        s0_next = '0;
        priority if (red >= mx)
        begin
            s0_next.side.sector = SEC_RED;
        end
        else if (green >= mx)
        begin
            s0_next.side.sector = SEC_GREEN;
        end
        else
        begin
            s0_next.side.sector = SEC_BLUE;
        end

        unique case (s0_next.side.sector)
            SEC_RED:
            begin
                op_a = green;
                op_b = blue;
            end
            SEC_GREEN:
            begin
                op_a = blue;
                op_b = red;
            end
            SEC_BLUE:
            begin
                op_a = red;
                op_b = green;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase

        s0_next.side.neg        = (op_a < op_b);
        s0_next.mag             = s0_next.side.neg ? (op_b - op_a) : (op_a - op_b);
        s0_next.spread          = mx - mn;
        s0_next.side.achromatic = (mx == mn);
        s0_next.side.brightness = mx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_reg <= s0_next;
        end
    end

    // hue:  (2*SECTOR*mag + spread) / (2*spread)
    // sat:  (2*spread*FS + max) / (2*max), FS*x = (x << CB) - x
    always_comb
    begin
        num_h_next = REM_BITS'(2 * SECTOR) * REM_BITS'(s0_reg.mag)
                   + REM_BITS'(s0_reg.spread);
        den_h_next = {s0_reg.spread, 1'b0};
        num_s_next = (REM_BITS'(s0_reg.spread) << (CB + 1))
                   - (REM_BITS'(s0_reg.spread) << 1)
                   + REM_BITS'(s0_reg.side.brightness);
        den_s_next = {s0_reg.side.brightness, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s0_valid_reg)
        begin
            s1_side_reg <= s0_reg.side;
            num_h_reg   <= num_h_next;
            num_s_reg   <= num_s_next;
            den_h_reg   <= den_h_next;
            den_s_reg   <= den_s_next;
        end
    end

    r2h_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (div_in_ready),
        .num_h     (num_h_reg),
        .den_h     (den_h_reg),
        .num_s     (num_s_reg),
        .den_s     (den_s_reg),
        .side_in   (s1_side_reg),
        .out_valid (div_out_valid),
        .out_ready (out_stage_ready),
        .quo_h     (div_quo_h),
        .quo_s     (div_quo_s),
        .side_out  (div_side)
    );

    assign qh = HUE_BITS'(div_quo_h);

    always_comb
    begin
        unique case (div_side.sector)
            SEC_RED:
            begin
                if (!div_side.neg)
                begin
                    hue_next = qh;
                end
                else if (qh == '0)
                begin
                    hue_next = '0;
                end
                else
                begin
                    hue_next = HUE_BITS'(6 * SECTOR) - qh;
                end
            end
            SEC_GREEN:
            begin
                hue_next = div_side.neg ? (HUE_BITS'(2 * SECTOR) - qh)
                                        : (HUE_BITS'(2 * SECTOR) + qh);
            end
            SEC_BLUE:
            begin
                hue_next = div_side.neg ? (HUE_BITS'(4 * SECTOR) - qh)
                                        : (HUE_BITS'(4 * SECTOR) + qh);
            end
            default:
            begin
                hue_next = '0;
            end
        endcase
        sat_next = CB'(div_quo_s);
        if (div_side.achromatic)
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_stage_ready)
        begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_stage_ready && div_out_valid)
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= div_side.brightness;
            achrom_reg <= div_side.achromatic;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;
    assign achromatic = achrom_reg;

    a_achrom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && achromatic |-> hue == '0 && saturation == '0)
        else $error("achromatic transfer with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue < HUE_BITS'(6 * SECTOR))
        else $error("hue out of range");

    a_chroma_bright: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !achromatic |-> brightness != '0)
        else $error("chromatic transfer with zero brightness");

endmodule

### rtl/r2h_div.sv
// r2h_div: dual pipelined restoring divider, one quotient bit per stage.
// Carries a side_t sideband alongside. Depends on r2h_pkg.
module r2h_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [r2h_pkg::REM_BITS-1:0]  num_h,
    input  logic [r2h_pkg::DEN_BITS-1:0]  den_h,
    input  logic [r2h_pkg::REM_BITS-1:0]  num_s,
    input  logic [r2h_pkg::DEN_BITS-1:0]  den_s,
    input  r2h_pkg::side_t              side_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [r2h_pkg::QUOT_BITS-1:0] quo_h,
    output logic [r2h_pkg::QUOT_BITS-1:0] quo_s,
    output r2h_pkg::side_t              side_out
);
    import r2h_pkg::*;

    localparam int STAGES = QUOT_BITS;

    logic                 valid_reg [STAGES];
    logic [STAGES:0]      stg_ready;
    logic [REM_BITS-1:0]  rem_h_reg [STAGES-1];
    logic [REM_BITS-1:0]  rem_s_reg [STAGES-1];
    logic [DEN_BITS-1:0]  den_h_reg [STAGES-1];
    logic [DEN_BITS-1:0]  den_s_reg [STAGES-1];
    logic [QUOT_BITS-1:0] quo_h_reg [STAGES];
    logic [QUOT_BITS-1:0] quo_s_reg [STAGES];
    side_t                side_reg  [STAGES];

    assign stg_ready[STAGES] = out_ready;
    assign in_ready          = stg_ready[0];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam int BIT = STAGES - 1 - k;

        logic                 v_in;
        logic [REM_BITS-1:0]  rh_in;
        logic [REM_BITS-1:0]  rs_in;
        logic [DEN_BITS-1:0]  dh_in;
        logic [DEN_BITS-1:0]  ds_in;
        logic [QUOT_BITS-1:0] qh_in;
        logic [QUOT_BITS-1:0] qs_in;
        side_t                sd_in;
        logic [REM_BITS-1:0]  shift_h;
        logic [REM_BITS-1:0]  shift_s;
        logic                 ge_h;
        logic                 ge_s;
        logic [QUOT_BITS-1:0] quo_h_next;
        logic [QUOT_BITS-1:0] quo_s_next;

        if (k == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign rh_in = num_h;
            assign rs_in = num_s;
            assign dh_in = den_h;
            assign ds_in = den_s;
            assign qh_in = '0;
            assign qs_in = '0;
            assign sd_in = side_in;
        end
        else
        begin : g_next
            assign v_in  = valid_reg[k-1];
            assign rh_in = rem_h_reg[k-1];
            assign rs_in = rem_s_reg[k-1];
            assign dh_in = den_h_reg[k-1];
            assign ds_in = den_s_reg[k-1];
            assign qh_in = quo_h_reg[k-1];
            assign qs_in = quo_s_reg[k-1];
            assign sd_in = side_reg[k-1];
        end

        assign shift_h    = REM_BITS'(dh_in) << BIT;
        assign shift_s    = REM_BITS'(ds_in) << BIT;
        assign ge_h       = (rh_in >= shift_h);
        assign ge_s       = (rs_in >= shift_s);
        assign quo_h_next = qh_in | (QUOT_BITS'(ge_h) << BIT);
        assign quo_s_next = qs_in | (QUOT_BITS'(ge_s) << BIT);

        assign stg_ready[k] = ~valid_reg[k] | stg_ready[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (stg_ready[k])
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_ready[k] && v_in)
            begin
                quo_h_reg[k] <= quo_h_next;
                quo_s_reg[k] <= quo_s_next;
                side_reg[k]  <= sd_in;
            end
        end

        if (k < STAGES - 1)
        begin : g_rem
            logic [REM_BITS-1:0] rem_h_next;
            logic [REM_BITS-1:0] rem_s_next;

            assign rem_h_next = ge_h ? (rh_in - shift_h) : rh_in;
            assign rem_s_next = ge_s ? (rs_in - shift_s) : rs_in;

            always_ff @(posedge clk)
            begin
                if (stg_ready[k] && v_in)
                begin
                    rem_h_reg[k] <= rem_h_next;
                    rem_s_reg[k] <= rem_s_next;
                    den_h_reg[k] <= dh_in;
                    den_s_reg[k] <= ds_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quo_h     = quo_h_reg[STAGES-1];
    assign quo_s     = quo_s_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule
